@@ rtl/mfr_pkg.sv @@
// Package for the marker framed float pair receiver.
// Holds widths, register indexes, config/item structs and the bound check.
// No dependencies.
package mfr_pkg;

    localparam int PAYLOAD_BYTES = 8;
    localparam int CNT_W         = $clog2(PAYLOAD_BYTES + 1);
    localparam int IDX_W         = $clog2(PAYLOAD_BYTES);
    localparam int BYTE_W        = 8;
    localparam int WORD_W        = 32;
    localparam int MAG_W         = 31;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_START_CODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_CODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND      = 2'd2;

    localparam logic [BYTE_W-1:0] START_CODE_RST = 8'd91;
    localparam logic [BYTE_W-1:0] END_CODE_RST   = 8'd93;
    localparam logic [MAG_W-1:0]  BOUND_RST      = 31'h461C_4000;
    localparam logic [MAG_W-1:0]  EXP_ALL_ONES   = 31'h7F80_0000;

    typedef struct packed {
        logic [BYTE_W-1:0] start_code;
        logic [BYTE_W-1:0] end_code;
        logic [MAG_W-1:0]  bound;
    } mfr_cfg_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] rx_byte;
    } mfr_item_t;

    // |value| > bound, false when either side is NaN
    function automatic logic exceeds(input logic [WORD_W-1:0] bits,
                                     input logic [MAG_W-1:0] bound);
        logic [MAG_W-1:0] mag;
        mag = bits[MAG_W-1:0];
        if ((mag > EXP_ALL_ONES) || (bound > EXP_ALL_ONES))
        begin
            return 1'b0;
        end
        return mag > bound;
    endfunction

endpackage

@@ rtl/mfr_if.sv @@
// Channel interfaces: received bytes, result pairs, config writes.
// Depends on mfr_pkg.
interface mfr_byte_if;
    logic                      valid;
    logic                      ready;
    logic [mfr_pkg::BYTE_W-1:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mfr_pair_if;
    logic                      valid;
    logic                      ready;
    logic [mfr_pkg::WORD_W-1:0] held_x;
    logic [mfr_pkg::WORD_W-1:0] held_y;
    logic                      rejected;
    modport source (output valid, output held_x, output held_y, output rejected, input ready);
    modport sink   (input valid, input held_x, input held_y, input rejected, output ready);
endinterface

interface mfr_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mfr_pkg::CFG_IDX_W-1:0]  index;
    logic [mfr_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/marker_framed_float_pair_receiver.sv @@
// Top level of the marker framed float pair receiver.
// Depends on mfr_pkg, mfr_if, mfr_cfg_regs, mfr_in_stage, mfr_framer.
//
//  channel | role   | payload                           | request
//  rx      | sink   | rx_byte[7:0]                      | valid && ready
//  res     | source | held_x[31:0] held_y[31:0] rejected| valid && ready
//  cfg     | sink   | index[1:0] data[31:0]             | valid && ready
//
// One byte per cycle sustained while no result waits; a result shows on res once
// its closing byte has passed the input register, then the result register.
// rx.ready drops only while a result waits on res.ready.
// cfg.ready is always high. Reset clears frame state and the held pair.
module marker_framed_float_pair_receiver (
    input  logic       clk,
    input  logic       rst_n,
    mfr_byte_if.sink   rx,
    mfr_pair_if.source res,
    mfr_cfg_if.sink    cfg
);
    import mfr_pkg::*;

    mfr_cfg_t  regs;
    mfr_item_t item;
    logic      advance;

    mfr_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    mfr_in_stage u_in (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx),
        .advance (advance),
        .item    (item)
    );

    mfr_framer u_frm (
        .clk     (clk),
        .rst_n   (rst_n),
        .regs    (regs),
        .item    (item),
        .advance (advance),
        .res     (res)
    );

endmodule

@@ rtl/mfr_cfg_regs.sv @@
// Configuration register file: start code, end code, magnitude bound.
// Depends on mfr_pkg and mfr_cfg_if.
module mfr_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    mfr_cfg_if.sink           cfg,
    output mfr_pkg::mfr_cfg_t regs
);
    import mfr_pkg::*;

    mfr_cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.start_code <= START_CODE_RST;
            regs_reg.end_code   <= END_CODE_RST;
            regs_reg.bound      <= BOUND_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_START_CODE: regs_reg.start_code <= cfg.data[BYTE_W-1:0];
                CFG_END_CODE:   regs_reg.end_code   <= cfg.data[BYTE_W-1:0];
                CFG_BOUND:      regs_reg.bound      <= cfg.data[MAG_W-1:0];
                default:        ;
            endcase
        end
    end

endmodule

@@ rtl/mfr_in_stage.sv @@
// Input register for received bytes, stalls when the result register is held.
// Depends on mfr_pkg and mfr_byte_if.
module mfr_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    mfr_byte_if.sink           rx,
    input  logic               advance,
    output mfr_pkg::mfr_item_t item
);
    import mfr_pkg::*;

    logic              valid_reg;
    logic [BYTE_W-1:0] byte_reg;

    assign rx.ready     = !valid_reg || advance;
    assign item.valid   = valid_reg;
    assign item.rx_byte = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            byte_reg <= rx.rx_byte;
        end
    end

endmodule

@@ rtl/mfr_framer.sv @@
// Frame tracking, payload store, float unpack and bound check, result register.
// Depends on mfr_pkg and mfr_pair_if.
module mfr_framer (
    input  logic               clk,
    input  logic               rst_n,
    input  mfr_pkg::mfr_cfg_t  regs,
    input  mfr_pkg::mfr_item_t item,
    output logic               advance,
    mfr_pair_if.source         res
);
    import mfr_pkg::*;

    logic              in_frame_reg, in_frame_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [BYTE_W-1:0] payload_reg [PAYLOAD_BYTES];
    logic [WORD_W-1:0] kept_x_reg, kept_y_reg;
    logic              out_valid_reg;
    logic              rejected_reg;

    logic              proc;
    logic              filling;
    logic              closing;
    logic              fire;
    logic              bad;
    logic [WORD_W-1:0] x_word, y_word;

    assign advance = !out_valid_reg || res.ready;
    assign proc    = item.valid && advance;
    assign filling = in_frame_reg && (count_reg < CNT_W'(PAYLOAD_BYTES));
    assign closing = in_frame_reg && !filling;
    assign fire    = proc && closing && (item.rx_byte == regs.end_code);

    assign x_word = {payload_reg[3], payload_reg[2], payload_reg[1], payload_reg[0]};
    assign y_word = {payload_reg[7], payload_reg[6], payload_reg[5], payload_reg[4]};
    assign bad    = exceeds(x_word, regs.bound) || exceeds(y_word, regs.bound);

    always_comb
    begin
        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        if (filling)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (closing)
        begin
            in_frame_next = 1'b0;
            count_next    = '0;
        end
        if (item.rx_byte == regs.start_code)
        begin
            in_frame_next = 1'b1;
            count_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg  <= 1'b0;
            count_reg     <= '0;
            kept_x_reg    <= '0;
            kept_y_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (proc)
            begin
                in_frame_reg <= in_frame_next;
                count_reg    <= count_next;
            end
            if (fire && !bad)
            begin
                kept_x_reg <= x_word;
                kept_y_reg <= y_word;
            end
            if (advance)
            begin
                out_valid_reg <= fire;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && filling)
        begin
            payload_reg[count_reg[IDX_W-1:0]] <= item.rx_byte;
        end
        if (fire)
        begin
            rejected_reg <= bad;
        end
    end

    assign res.valid    = out_valid_reg;
    assign res.held_x   = kept_x_reg;
    assign res.held_y   = kept_y_reg;
    assign res.rejected = rejected_reg;

endmodule

@@ rtl/mfr_checker.sv @@
// Port-level checks for the receiver, bound to the top level.
// Depends on marker_framed_float_pair_receiver.
module mfr_checker (
    input logic clk,
    input logic rst_n,
    input logic rx_valid,
    input logic rx_ready,
    input logic res_valid,
    input logic res_ready
);

    logic rx_req;

    assign rx_req = rx_valid && rx_ready;

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_rx_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !rx_ready |-> res_valid && !res_ready)
        else $error("input stalled without a held result");

    a_res_origin: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !$past(res_valid) |-> $past(rx_req, 2))
        else $error("result without a request two cycles earlier");

endmodule

bind marker_framed_float_pair_receiver mfr_checker u_mfr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rx_valid  (rx.valid),
    .rx_ready  (rx.ready),
    .res_valid (res.valid),
    .res_ready (res.ready)
);
